// ----- src/integer_to_digit_string_assert.svh -----
// assertion helpers used by the rtl top level
`ifndef INTEGER_TO_DIGIT_STRING_ASSERT_SVH
`define INTEGER_TO_DIGIT_STRING_ASSERT_SVH

// overlapping implication, checked out of reset
`define ITDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ITDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/itds_pkg.sv -----
package itds_pkg;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] DEC_DIGITS  = 6'd10;
  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_A      = 7'd65;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic       start;
    logic [6:0] count;
  } emit_cmd_t;

  function automatic logic [5:0] eff_base(input logic [5:0] r);
    logic [5:0] b;
    b = r;
    if (b < RADIX_MIN) b = RADIX_MIN;
    if (b > RADIX_MAX) b = RADIX_MAX;
    return b;
  endfunction

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    logic [6:0] c;
    if (d < DEC_DIGITS) c = CHAR_ZERO + {1'b0, d};
    else c = CHAR_A + {1'b0, d - DEC_DIGITS};
    return c;
  endfunction

endpackage

// ----- src/itds_divider.sv -----
module itds_divider import itds_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [5:0]   base_i,
  output div_stat_t    stat_o,
  output logic [W-1:0] quot_o,
  output logic [5:0]   rem_o
);

  localparam int CNTW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    quot_q, quot_d;
  logic [5:0]      rem_q, rem_d;
  logic [5:0]      base_q, base_d;
  logic [6:0]      trial;
  logic            ge;

  // one quotient bit per cycle, msb first
  assign trial = {rem_q, quot_q[W-1]};
  assign ge    = trial >= {1'b0, base_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    base_d = base_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      base_d = base_i;
    end else if (busy_q) begin
      quot_d = {quot_q[W-2:0], ge};
      rem_d  = ge ? 6'(trial - {1'b0, base_q}) : trial[5:0];
      cnt_d  = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    base_q <= base_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

// ----- src/itds_emitter.sv -----
module itds_emitter import itds_pkg::*; #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_DIGITS)-1:0] wr_addr_i,
  input  logic [5:0]                    wr_data_i,
  input  emit_cmd_t                     cmd_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [6:0]                    digit_char_o,
  output logic                          is_last_o,
  output logic [6:0]                    digit_count_o
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [5:0]    mem [MAX_DIGITS];

  logic          busy_q;
  logic [CW-1:0] left_q;
  logic [6:0]    count_q;
  logic          rd_vld_q;
  logic [5:0]    rd_data_q;
  logic          rd_last_q;
  logic          out_vld_q;
  logic [6:0]    out_char_q;
  logic          out_last_q;
  logic [6:0]    out_cnt_q;
  logic          issue, move;
  logic [AW-1:0] rd_addr;

  // read stage refills when empty or its digit moves on, if digits remain
  assign move    = rd_vld_q && (!out_vld_q || !out_stall_i);
  assign issue   = (left_q != '0) && (!rd_vld_q || move);
  assign rd_addr = AW'(left_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[rd_addr];
      rd_last_q <= (left_q == CW'(1));
    end
    if (cmd_i.start) count_q <= cmd_i.count;
    if (move) begin
      out_char_q <= digit_to_ascii(rd_data_q);
      out_last_q <= rd_last_q;
      out_cnt_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      left_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        left_q <= cmd_i.count[CW-1:0];
      end else begin
        if (move && rd_last_q) busy_q <= 1'b0;
        if (issue) left_q <= left_q - CW'(1);
      end
      if (issue) rd_vld_q <= 1'b1;
      else if (move) rd_vld_q <= 1'b0;
      if (move) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  assign busy_o        = busy_q;
  assign out_valid_o   = out_vld_q;
  assign digit_char_o  = out_char_q;
  assign is_last_o     = out_last_q;
  assign digit_count_o = out_cnt_q;

endmodule

// ----- src/integer_to_digit_string.sv -----
// Converts one unsigned value into ASCII digits in the base held in radix.
// Input channel: value_i with in_valid_i / in_stall_o; a request is taken
// when in_valid_i is high and in_stall_o is low. Output channel: one request
// per digit (digit_char_o, is_last_o, digit_count_o) with out_valid_o /
// out_stall_i, most significant digit first, is_last_o on the final digit.
// radix_we_i writes radix_i into the base register; bases outside 2..36 are
// clamped. Write it only while the block is idle.
// Each digit takes one pass of the bit-serial divider (one quotient bit per
// cycle); the digits then stream out of the digit memory through a read
// register and an output register, one per cycle while out_stall_i is low.
// in_stall_o stays high from the accepted request until the cycle after the
// last digit has reached the output register, so the next value is divided
// while the last digit of the previous one still waits. A stalled output
// holds its digit and the read stage behind it; nothing is dropped.
// Reset clears the control state and sets radix to 10; the digit memory is
// not cleared and needs no clearing pass.
`include "integer_to_digit_string_assert.svh"

module integer_to_digit_string import itds_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        radix_we_i,
  input  logic [5:0]  radix_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  digit_char_o,
  output logic        is_last_o,
  output logic [6:0]  digit_count_o
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [5:0]             radix_q;
  logic [CW-1:0]          cnt_next;
  logic                   accept;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [5:0]             div_rem;
  logic [5:0]             base;
  logic                   wr_en;
  emit_cmd_t              emit_cmd;
  logic                   emit_busy;

  assign base     = eff_base(radix_q);
  assign accept   = in_valid_i && !in_stall_o;
  assign cnt_next = cnt_q + CW'(1);
  assign wr_en    = (state_q == S_DIV) && div_stat.done;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    div_start      = 1'b0;
    div_dividend   = value_i[VALUE_WIDTH-1:0];
    emit_cmd.start = 1'b0;
    emit_cmd.count = 7'(cnt_next);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          div_start = 1'b1;
          cnt_d     = '0;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          cnt_d = cnt_next;
          // keep dividing until the quotient runs out or the store is full
          if ((div_quot != '0) && (cnt_next < CW'(MAX_DIGITS))) begin
            div_start    = 1'b1;
            div_dividend = div_quot;
          end else begin
            emit_cmd.start = 1'b1;
            state_d        = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!emit_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      radix_q <= RADIX_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (radix_we_i) radix_q <= radix_i;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  itds_divider #(
    .W (VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .base_i     (base),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  itds_emitter #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_addr_i     (cnt_q[AW-1:0]),
    .wr_data_i     (div_rem),
    .cmd_i         (emit_cmd),
    .busy_o        (emit_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_char_o  (digit_char_o),
    .is_last_o     (is_last_o),
    .digit_count_o (digit_count_o)
  );

  `ITDS_ASSERT_NXT(a_accept_starts_div, clk_i, rst_ni, accept,
                   state_q == S_DIV, "accepted value did not start division")
  `ITDS_ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, div_stat.busy || div_stat.done,
                   state_q == S_DIV, "divider active outside division")
  `ITDS_ASSERT_IMP(a_rem_below_base, clk_i, rst_ni, wr_en,
                   div_rem < base, "remainder not below base")
  `ITDS_ASSERT_IMP(a_emit_count_range, clk_i, rst_ni, state_q == S_EMIT,
                   (cnt_q != '0) && (cnt_q <= CW'(MAX_DIGITS)), "digit count out of range")

endmodule
